[design/fgd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgd_pkg
// Shared types, constants and code tables of the Group 3 run-length decoder.
// ----------------------------------------------------------------------------
package fgd_pkg;

  localparam int unsigned ColW     = 11;
  localparam logic [10:0] RowWidth = 11'd1728;
  localparam logic [3:0]  MaxCodeBits = 4'd13;
  localparam logic [4:0]  EolZeros = 5'd11;

  // configuration register indexes
  localparam logic [1:0] CFG_LSB_FIRST  = 2'd0;
  localparam logic [1:0] CFG_SYNC_EOLS  = 2'd1;
  localparam logic [1:0] CFG_PAGE_EOLS  = 2'd2;

  // decoder modes
  localparam logic [1:0] MODE_SYNC = 2'd0;
  localparam logic [1:0] MODE_ROW  = 2'd1;
  localparam logic [1:0] MODE_SKIP = 2'd2;
  localparam logic [1:0] MODE_DONE = 2'd3;

  // result kinds
  localparam logic [2:0] EV_WHITE = 3'd0;
  localparam logic [2:0] EV_BLACK = 3'd1;
  localparam logic [2:0] EV_ROW   = 3'd2;
  localparam logic [2:0] EV_PAGE  = 3'd3;
  localparam logic [2:0] EV_ERR   = 3'd4;

  typedef struct packed {
    logic [7:0] bits;  // bit 0 is decoded first
    logic       eod;
  } item_t;

  typedef struct packed {
    logic [2:0]  ev;
    logic [10:0] start;
    logic [10:0] len;
    logic        last;
  } res_t;

  typedef struct packed {
    logic        hit;
    logic [11:0] count;
  } match_t;

  // entry = length (4 bits) above code (13 bits)
  localparam logic [16:0] WHITE_CODES [91] = '{
    {4'd8,13'h35},{4'd6,13'h7},{4'd4,13'h7},{4'd4,13'h8},{4'd4,13'hb},{4'd4,13'hc},
    {4'd4,13'he},{4'd4,13'hf},{4'd5,13'h13},{4'd5,13'h14},{4'd5,13'h7},{4'd5,13'h8},
    {4'd6,13'h8},{4'd6,13'h3},{4'd6,13'h34},{4'd6,13'h35},{4'd6,13'h2a},{4'd6,13'h2b},
    {4'd7,13'h27},{4'd7,13'hc},{4'd7,13'h8},{4'd7,13'h17},{4'd7,13'h3},{4'd7,13'h4},
    {4'd7,13'h28},{4'd7,13'h2b},{4'd7,13'h13},{4'd7,13'h24},{4'd7,13'h18},{4'd8,13'h2},
    {4'd8,13'h3},{4'd8,13'h1a},{4'd8,13'h1b},{4'd8,13'h12},{4'd8,13'h13},{4'd8,13'h14},
    {4'd8,13'h15},{4'd8,13'h16},{4'd8,13'h17},{4'd8,13'h28},{4'd8,13'h29},{4'd8,13'h2a},
    {4'd8,13'h2b},{4'd8,13'h2c},{4'd8,13'h2d},{4'd8,13'h4},{4'd8,13'h5},{4'd8,13'ha},
    {4'd8,13'hb},{4'd8,13'h52},{4'd8,13'h53},{4'd8,13'h54},{4'd8,13'h55},{4'd8,13'h24},
    {4'd8,13'h25},{4'd8,13'h58},{4'd8,13'h59},{4'd8,13'h5a},{4'd8,13'h5b},{4'd8,13'h4a},
    {4'd8,13'h4b},{4'd8,13'h32},{4'd8,13'h33},{4'd8,13'h34},
    {4'd5,13'h1b},{4'd5,13'h12},{4'd6,13'h17},{4'd7,13'h37},{4'd8,13'h36},{4'd8,13'h37},
    {4'd8,13'h64},{4'd8,13'h65},{4'd8,13'h68},{4'd8,13'h67},{4'd9,13'hcc},{4'd9,13'hcd},
    {4'd9,13'hd2},{4'd9,13'hd3},{4'd9,13'hd4},{4'd9,13'hd5},{4'd9,13'hd6},{4'd9,13'hd7},
    {4'd9,13'hd8},{4'd9,13'hd9},{4'd9,13'hda},{4'd9,13'hdb},{4'd9,13'h98},{4'd9,13'h99},
    {4'd9,13'h9a},{4'd6,13'h18},{4'd9,13'h9b}
  };

  localparam logic [16:0] BLACK_CODES [91] = '{
    {4'd10,13'h37},{4'd3,13'h2},{4'd2,13'h3},{4'd2,13'h2},{4'd3,13'h3},{4'd4,13'h3},
    {4'd4,13'h2},{4'd5,13'h3},{4'd6,13'h5},{4'd6,13'h4},{4'd7,13'h4},{4'd7,13'h5},
    {4'd7,13'h7},{4'd8,13'h4},{4'd8,13'h7},{4'd9,13'h18},{4'd10,13'h17},{4'd10,13'h18},
    {4'd10,13'h8},{4'd11,13'h67},{4'd11,13'h68},{4'd11,13'h6c},{4'd11,13'h37},
    {4'd11,13'h28},{4'd11,13'h17},{4'd11,13'h18},{4'd12,13'hca},{4'd12,13'hcb},
    {4'd12,13'hcc},{4'd12,13'hcd},{4'd12,13'h68},{4'd12,13'h69},{4'd12,13'h6a},
    {4'd12,13'h6b},{4'd12,13'hd2},{4'd12,13'hd3},{4'd12,13'hd4},{4'd12,13'hd5},
    {4'd12,13'hd6},{4'd12,13'hd7},{4'd12,13'h6c},{4'd12,13'h6d},{4'd12,13'hda},
    {4'd12,13'hdb},{4'd12,13'h54},{4'd12,13'h55},{4'd12,13'h56},{4'd12,13'h57},
    {4'd12,13'h64},{4'd12,13'h65},{4'd12,13'h52},{4'd12,13'h53},{4'd12,13'h24},
    {4'd12,13'h37},{4'd12,13'h38},{4'd12,13'h27},{4'd12,13'h28},{4'd12,13'h58},
    {4'd12,13'h59},{4'd12,13'h2b},{4'd12,13'h2c},{4'd12,13'h5a},{4'd12,13'h66},
    {4'd12,13'h67},
    {4'd10,13'hf},{4'd12,13'hc8},{4'd12,13'hc9},{4'd12,13'h5b},{4'd12,13'h33},
    {4'd12,13'h34},{4'd12,13'h35},{4'd13,13'h6c},{4'd13,13'h6d},{4'd13,13'h4a},
    {4'd13,13'h4b},{4'd13,13'h4c},{4'd13,13'h4d},{4'd13,13'h72},{4'd13,13'h73},
    {4'd13,13'h74},{4'd13,13'h75},{4'd13,13'h76},{4'd13,13'h77},{4'd13,13'h52},
    {4'd13,13'h53},{4'd13,13'h54},{4'd13,13'h55},{4'd13,13'h5a},{4'd13,13'h5b},
    {4'd13,13'h64},{4'd13,13'h65}
  };

  localparam logic [16:0] EXT_CODES [13] = '{
    {4'd11,13'h8},{4'd11,13'hc},{4'd11,13'hd},{4'd12,13'h12},{4'd12,13'h13},
    {4'd12,13'h14},{4'd12,13'h15},{4'd12,13'h16},{4'd12,13'h17},{4'd12,13'h1c},
    {4'd12,13'h1d},{4'd12,13'h1e},{4'd12,13'h1f}
  };

  // Parallel compare of the collected code word against the color's table.
  function automatic match_t code_lookup(input logic color, input logic [3:0] len,
                                         input logic [12:0] bits);
    match_t      m;
    logic [16:0] key;
    m   = '0;
    key = {len, bits};
    for (int i = 0; i < 91; i++) begin
      if ((color ? BLACK_CODES[i] : WHITE_CODES[i]) == key) begin
        m.hit   = 1'b1;
        m.count = (i < 64) ? 12'(i) : 12'(64 * (i - 63));
      end
    end
    for (int j = 0; j < 13; j++) begin
      if (EXT_CODES[j] == key) begin
        m.hit   = 1'b1;
        m.count = 12'(1792 + 64 * j);
      end
    end
    return m;
  endfunction

endpackage

[design/fax_g3_run_length_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fax_g3_run_length_decoder
// Group 3 one-dimensional fax decoder: coded bytes in, run events out.
// ----------------------------------------------------------------------------
// Input channel (s_axis): one coded byte per transaction in tdata; tuser set
// marks end of data (byte ignored, row and page closed). Output channel
// (m_axis): one event per transaction, kind in tuser, column and length in
// tdata, tlast on the final event that a byte causes.
// Bits are decoded one per clock while the engine is not stalled; a bit that
// yields two events emits its second event in a step of its own before the
// next bit. The bit engine is the throughput limit. With the engine idle,
// the bits of an accepted byte are decoded in order. An event waits in a
// hold register and enters the result queue when the step yielding the next
// event ends, or once the step that completes its byte has set its tlast.
// A two-entry input queue decouples the sender; a two-entry result queue
// lets the engine keep running while the receiver stalls, after which the
// engine and then the input side stall in turn.
// Reset clears all state: the decoder waits for sync_eols_to_skip ends of
// line, registers return to lsb_first 0, sync 1, page 3.
// Configuration (cfg_*) must be written only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module fax_g3_run_length_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [2:0]  cfg_data_i,
  // coded byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] end_of_data
  // decoded events
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [10:0] run_start, [21:11] run_length, rest 0
  output logic [2:0]  m_axis_tuser,   // [2:0] event_res
  output logic        m_axis_tlast
);

  logic             item_valid, item_pop;
  fgd_pkg::item_t   item;
  fgd_pkg::res_t    res;

  // front: accept and reorder bits into decode order
  fgd_front u_front (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // back: bit engine and result queue
  fgd_engine u_engine (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_valid_o  (m_axis_tvalid),
    .res_o        (res),
    .res_ready_i  (m_axis_tready)
  );

  // pack the event fields onto the stream
  assign m_axis_tdata = {2'b00, res.len, res.start};
  assign m_axis_tuser = res.ev;
  assign m_axis_tlast = res.last;

endmodule

[design/fgd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgd_front
// Input side: accept coded bytes, put bits in decode order, two-entry queue.
// ----------------------------------------------------------------------------
module fgd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [2:0]        cfg_data_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,
  input  logic              s_axis_tuser,
  output logic              item_valid_o,
  output fgd_pkg::item_t    item_o,
  input  logic              item_pop_i
);

  logic              lsb_first_q;
  fgd_pkg::item_t    slot_q [2];
  logic [1:0]        cnt_q;
  logic              rd_q, wr_q;
  fgd_pkg::item_t    in_item;
  logic              push, pop;

  always_comb begin
    in_item.eod = s_axis_tuser;
    for (int i = 0; i < 8; i++) begin
      in_item.bits[i] = lsb_first_q ? s_axis_tdata[i] : s_axis_tdata[7 - i];
    end
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = item_pop_i && item_valid_o;
  assign item_valid_o  = (cnt_q != 2'd0);
  assign item_o        = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lsb_first_q <= 1'b0;
      cnt_q       <= 2'd0;
      rd_q        <= 1'b0;
      wr_q        <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == fgd_pkg::CFG_LSB_FIRST) begin
        lsb_first_q <= cfg_data_i[0];
      end
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= in_item;
  end

endmodule

[design/fgd_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgd_engine
// Back side: decode one bit per cycle unless stalled, hold the newest result
// to mark the last one of each byte, and queue results for the output channel.
// ----------------------------------------------------------------------------
module fgd_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [2:0]        cfg_data_i,
  input  logic              item_valid_i,
  input  fgd_pkg::item_t    item_i,
  output logic              item_pop_o,
  output logic              res_valid_o,
  output fgd_pkg::res_t     res_o,
  input  logic              res_ready_i
);

  // configuration
  logic [2:0]  page_eols_q;
  // decoder state
  logic [1:0]  mode_q, mode_d;
  logic [10:0] col_q, col_d;
  logic [13:0] cb_q, cb_d;
  logic [3:0]  cl_q, cl_d;
  logic [12:0] pend_q, pend_d;
  logic        color_q, color_d;
  logic [4:0]  zr_q, zr_d;
  logic [2:0]  er_q, er_d;
  logic [2:0]  sl_q, sl_d;
  logic [2:0]  bit_q;
  // second result of one bit, result hold and output queue
  logic             sec_v_q, sec_fin_q;
  fgd_pkg::res_t    sec_q;
  logic             hold_v_q;
  fgd_pkg::res_t    hold_q;
  fgd_pkg::res_t    oq_q [2];
  logic [1:0]       ocnt_q;
  logic             ord_q, owr_q;

  logic             b, eol, do_eol, stall, fin, final_step, new_v, push, opop;
  logic             r1v, r2v, over, was_row;
  fgd_pkg::res_t    r1, r2, new_r;
  fgd_pkg::match_t  mt;
  logic [13:0]      psum, csum;
  logic [12:0]      run;

  assign stall      = hold_v_q && (ocnt_q == 2'd2);
  assign final_step = item_i.eod || (bit_q == 3'd7);
  assign b          = item_i.bits[bit_q];
  assign eol        = b && (zr_q >= fgd_pkg::EolZeros);

  // one bit (or the end-of-data mark) against the current state
  always_comb begin
    mode_d = mode_q; col_d = col_q; cb_d = cb_q; cl_d = cl_q; pend_d = pend_q;
    color_d = color_q; zr_d = zr_q; er_d = er_q; sl_d = sl_q;
    r1v = 1'b0; r2v = 1'b0; r1 = '0; r2 = '0; do_eol = 1'b0; was_row = 1'b0;
    mt = '0; psum = '0; csum = '0; run = '0; over = 1'b0;
    if (item_i.eod) begin
      if (mode_q == fgd_pkg::MODE_ROW || mode_q == fgd_pkg::MODE_SKIP) begin
        r1v = 1'b1; r1.ev = fgd_pkg::EV_ROW; r1.len = col_q;
        r2v = 1'b1; r2.ev = fgd_pkg::EV_PAGE;
      end else if (mode_q == fgd_pkg::MODE_SYNC) begin
        r1v = 1'b1; r1.ev = fgd_pkg::EV_PAGE;
      end
      mode_d = fgd_pkg::MODE_DONE;
    end else begin
      zr_d = b ? 5'd0 : ((zr_q != 5'd31) ? zr_q + 5'd1 : zr_q);
      if (mode_d == fgd_pkg::MODE_SYNC && sl_q == 3'd0) begin
        mode_d = fgd_pkg::MODE_ROW;
        col_d = '0; cb_d = '0; cl_d = '0; pend_d = '0; color_d = 1'b0;
      end else if (mode_d == fgd_pkg::MODE_SYNC && eol) begin
        sl_d = sl_q - 3'd1;
        if (sl_d == 3'd0) begin
          mode_d = fgd_pkg::MODE_ROW;
          col_d = '0; cb_d = '0; cl_d = '0; pend_d = '0; color_d = 1'b0;
        end
      end
      if (mode_q != fgd_pkg::MODE_SYNC || sl_q == 3'd0) begin
        if (mode_d == fgd_pkg::MODE_SKIP || mode_d == fgd_pkg::MODE_ROW) begin
          if (eol) begin
            do_eol  = 1'b1;
            was_row = (mode_d == fgd_pkg::MODE_ROW);
          end else if (mode_d == fgd_pkg::MODE_ROW) begin
            cb_d = {cb_d[12:0], b};
            if (cl_d != 4'd15) cl_d = cl_d + 4'd1;
            if (cb_d != 14'd0) begin
              if (cl_d > fgd_pkg::MaxCodeBits) begin
                r1v = 1'b1; r1.ev = fgd_pkg::EV_ERR; r1.start = col_d;
                mode_d = fgd_pkg::MODE_SKIP;
              end else begin
                mt = fgd_pkg::code_lookup(color_d, cl_d, cb_d[12:0]);
                if (mt.hit) begin
                  cb_d = '0; cl_d = '0;
                  psum = {1'b0, pend_d} + {2'b0, mt.count};
                  pend_d = psum[13] ? 13'h1fff : psum[12:0];
                  if (mt.count[11:6] == 6'd0) begin
                    run  = pend_d;
                    csum = {3'b0, col_d} + {1'b0, run};
                    over = (csum > {3'b0, fgd_pkg::RowWidth});
                    if (over) run = {2'b0, fgd_pkg::RowWidth - col_d};
                    if (run != 13'd0) begin
                      r1v = 1'b1;
                      r1.ev = color_d ? fgd_pkg::EV_BLACK : fgd_pkg::EV_WHITE;
                      r1.start = col_d; r1.len = run[10:0];
                    end
                    col_d   = col_d + run[10:0];
                    pend_d  = '0;
                    color_d = ~color_d;
                    if (over) begin
                      if (r1v) begin
                        r2v = 1'b1; r2.ev = fgd_pkg::EV_ERR; r2.start = col_d;
                      end else begin
                        r1v = 1'b1; r1.ev = fgd_pkg::EV_ERR; r1.start = col_d;
                      end
                      mode_d = fgd_pkg::MODE_SKIP;
                    end else if (col_d >= fgd_pkg::RowWidth) begin
                      mode_d = fgd_pkg::MODE_SKIP;
                    end
                  end
                end
              end
            end
          end
        end
      end
      // close the row; count empty rows toward end of page
      if (do_eol) begin
        r1v = 1'b1; r1.ev = fgd_pkg::EV_ROW; r1.start = '0; r1.len = col_d;
        mode_d = fgd_pkg::MODE_ROW;
        if (was_row && col_d == 11'd0) begin
          if (er_q != 3'd7) er_d = er_q + 3'd1;
          if (er_d >= page_eols_q) begin
            r2v = 1'b1; r2.ev = fgd_pkg::EV_PAGE;
            mode_d = fgd_pkg::MODE_DONE;
          end
        end else begin
          er_d = '0;
        end
        if (mode_d == fgd_pkg::MODE_ROW) begin
          col_d = '0; cb_d = '0; cl_d = '0; pend_d = '0; color_d = 1'b0;
        end
      end
    end
  end

  // step selection: a held second result goes first
  always_comb begin
    if (sec_v_q) begin
      new_v = 1'b1;
      new_r = sec_q;
      fin   = sec_fin_q;
    end else begin
      new_v = item_valid_i && r1v;
      new_r = r1;
      fin   = item_valid_i && final_step && !r2v;
    end
    new_r.last = fin;
  end

  assign item_pop_o  = !stall && !sec_v_q && item_valid_i && final_step;
  assign push        = !stall && hold_v_q && (hold_q.last || new_v);
  assign res_valid_o = (ocnt_q != 2'd0);
  assign res_o       = oq_q[ord_q];
  assign opop        = res_valid_o && res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_eols_q <= 3'd3;
      mode_q  <= fgd_pkg::MODE_SYNC;
      col_q   <= '0;
      cb_q    <= '0;
      cl_q    <= '0;
      pend_q  <= '0;
      color_q <= 1'b0;
      zr_q    <= '0;
      er_q    <= '0;
      sl_q    <= 3'd1;
      bit_q   <= '0;
      sec_v_q <= 1'b0;
      sec_q   <= '0;
      sec_fin_q <= 1'b0;
      hold_v_q  <= 1'b0;
      hold_q    <= '0;
      ocnt_q  <= '0;
      ord_q   <= 1'b0;
      owr_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          fgd_pkg::CFG_SYNC_EOLS: begin
            if (mode_q == fgd_pkg::MODE_SYNC) sl_q <= cfg_data_i;
          end
          fgd_pkg::CFG_PAGE_EOLS: page_eols_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (!stall) begin
        if (sec_v_q) begin
          sec_v_q <= 1'b0;
        end else if (item_valid_i) begin
          mode_q <= mode_d; col_q <= col_d; cb_q <= cb_d; cl_q <= cl_d;
          pend_q <= pend_d; color_q <= color_d; zr_q <= zr_d; er_q <= er_d;
          if (!(cfg_we_i && cfg_idx_i == fgd_pkg::CFG_SYNC_EOLS)) sl_q <= sl_d;
          bit_q     <= final_step ? 3'd0 : bit_q + 3'd1;
          sec_v_q   <= r2v;
          sec_q     <= r2;
          sec_fin_q <= final_step;
        end
        // keep the newest result back until its last flag is known
        if (new_v) begin
          hold_v_q <= 1'b1;
          hold_q   <= new_r;
        end else if (push) begin
          hold_v_q <= 1'b0;
        end else if (fin && hold_v_q) begin
          hold_q.last <= 1'b1;
        end
      end
      if (push) owr_q <= ~owr_q;
      if (opop) ord_q <= ~ord_q;
      ocnt_q <= ocnt_q + {1'b0, push} - {1'b0, opop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) oq_q[owr_q] <= hold_q;
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (ocnt_q != 2'd2))
    else $error("result queue written while full");
  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= fgd_pkg::RowWidth)
    else $error("column passed the row width");
  a_done_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == fgd_pkg::MODE_DONE) |=> (mode_q == fgd_pkg::MODE_DONE))
    else $error("decoder left the page-done mode");
  a_sec_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_v_q |-> !item_pop_o)
    else $error("input popped while a second result waits");

endmodule

[tb/tb_fax_g3_run_length_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fax_g3_run_length_decoder
// Self-checking bench for the Group 3 run-length decoder. The stimulus is
// built as coded bit lines: well-formed rows, full rows, overflows, long
// codes, ends of line in the middle of a code, empty rows and noise. These
// lines are packed into bytes in the configured bit order. A bit-serial
// decoder model predicts every event, and each event from the block is
// checked in order against it. The bench runs several idle and stall phases
// and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_fax_g3_run_length_decoder;

  localparam int IdleLimit = 5000;
  localparam int DrainCycles = 40;
  localparam int HoldCycles = 400;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [2:0]  cfg_data_i;
  logic        s_axis_tvalid, s_axis_tready;
  logic [7:0]  s_axis_tdata;    // [7:0] data_byte
  logic        s_axis_tuser;    // [0] end_of_data
  logic        m_axis_tvalid, m_axis_tready;
  logic [23:0] m_axis_tdata;    // [10:0] run_start, [21:11] run_length
  logic [2:0]  m_axis_tuser;    // [2:0] event_res
  logic        m_axis_tlast;

  fax_g3_run_length_decoder u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Bytes waiting for the driver, and events the decoder model expects.
  fgd_pkg::item_t byte_q[$];
  fgd_pkg::res_t  event_q[$];
  fgd_pkg::res_t  step_events[$];
  int             bytes_queued;

  // Traffic shaping, set per phase.
  int gap_pct, stall_pct;
  int hold_reqs, hold_seen, hold_left;
  logic s_fire;

  int mismatches;
  int idle_cycles;

  // --------------------------------------------------------------------------
  // Decoder model: one bit at a time, same state as the block.
  // --------------------------------------------------------------------------
  int          lsb_cfg, page_cfg;
  int          col, code_len, pend_run, zero_cnt, empty_cnt, sync_cnt;
  logic [13:0] code_acc;
  logic        run_color;
  logic [1:0]  dec_mode;

  task automatic push_event(input logic [2:0] ev, input int start, input int len);
    fgd_pkg::res_t r;
    if (step_events.size() < 8) begin
      r.ev    = ev;
      r.start = 11'(start);
      r.len   = 11'(len);
      r.last  = 1'b0;
      step_events.push_back(r);
    end
  endtask

  task automatic restart_row();
    col       = 0;
    code_acc  = '0;
    code_len  = 0;
    pend_run  = 0;
    run_color = 1'b0;
  endtask

  function automatic bit code_hit(input logic color, input int len, input logic [13:0] acc,
                                  output int pixels);
    logic [16:0] key;
    bit          hit;
    key    = {4'(len), acc[12:0]};
    hit    = 1'b0;
    pixels = 0;
    for (int i = 0; i < 91; i++) begin
      if ((color ? fgd_pkg::BLACK_CODES[i] : fgd_pkg::WHITE_CODES[i]) == key) begin
        hit    = 1'b1;
        pixels = (i < 64) ? i : 64 * (i - 63);
      end
    end
    for (int j = 0; j < 13; j++) begin
      if (fgd_pkg::EXT_CODES[j] == key) begin
        hit    = 1'b1;
        pixels = 1792 + 64 * j;
      end
    end
    return hit;
  endfunction

  task automatic close_line();
    push_event(fgd_pkg::EV_ROW, 0, col);
    if (dec_mode == fgd_pkg::MODE_ROW && col == 0) begin
      if (empty_cnt < 7) empty_cnt++;
      if (empty_cnt >= page_cfg) begin
        push_event(fgd_pkg::EV_PAGE, 0, 0);
        dec_mode = fgd_pkg::MODE_DONE;
        return;
      end
    end else begin
      empty_cnt = 0;
    end
    dec_mode = fgd_pkg::MODE_ROW;
    restart_row();
  endtask

  task automatic decode_bit(input logic b);
    bit eol, over;
    int pixels, run;
    eol      = b && (zero_cnt >= 11);
    zero_cnt = b ? 0 : (zero_cnt < 31 ? zero_cnt + 1 : 31);
    if (dec_mode == fgd_pkg::MODE_SYNC && sync_cnt == 0) begin
      dec_mode = fgd_pkg::MODE_ROW;
      restart_row();
    end
    if (dec_mode == fgd_pkg::MODE_SYNC) begin
      if (eol) begin
        sync_cnt--;
        if (sync_cnt == 0) begin
          dec_mode = fgd_pkg::MODE_ROW;
          restart_row();
        end
      end
      return;
    end
    if (dec_mode == fgd_pkg::MODE_SKIP) begin
      if (eol) close_line();
      return;
    end
    if (dec_mode != fgd_pkg::MODE_ROW) return;
    if (eol) begin
      close_line();
      return;
    end
    code_acc = {code_acc[12:0], b};
    if (code_len < 15) code_len++;
    if (code_acc == '0) return;
    if (code_len > 13) begin
      push_event(fgd_pkg::EV_ERR, col, 0);
      dec_mode = fgd_pkg::MODE_SKIP;
      return;
    end
    if (!code_hit(run_color, code_len, code_acc, pixels)) return;
    code_acc = '0;
    code_len = 0;
    pend_run = (pend_run + pixels > 8191) ? 8191 : pend_run + pixels;
    if (pixels >= 64) return;
    run  = pend_run;
    over = (col + run > 1728);
    if (over) run = 1728 - col;
    if (run > 0) push_event(run_color ? fgd_pkg::EV_BLACK : fgd_pkg::EV_WHITE, col, run);
    col      += run;
    pend_run  = 0;
    run_color = ~run_color;
    if (over) begin
      push_event(fgd_pkg::EV_ERR, col, 0);
      dec_mode = fgd_pkg::MODE_SKIP;
    end else if (col >= 1728) begin
      dec_mode = fgd_pkg::MODE_SKIP;
    end
  endtask

  task automatic decode_byte(input logic [7:0] data, input logic eod);
    step_events.delete();
    if (eod) begin
      if (dec_mode == fgd_pkg::MODE_ROW || dec_mode == fgd_pkg::MODE_SKIP)
        push_event(fgd_pkg::EV_ROW, 0, col);
      if (dec_mode != fgd_pkg::MODE_DONE) begin
        push_event(fgd_pkg::EV_PAGE, 0, 0);
        dec_mode = fgd_pkg::MODE_DONE;
      end
    end else begin
      for (int i = 0; i < 8; i++) decode_bit(data[lsb_cfg ? i : 7 - i]);
    end
    if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
    foreach (step_events[k]) event_q.push_back(step_events[k]);
  endtask

  // --------------------------------------------------------------------------
  // Line encoder: builds coded bits, packs them into bytes for the driver.
  // --------------------------------------------------------------------------
  bit line_bits[$];

  task automatic put_bits(input int value, input int n);
    for (int i = n - 1; i >= 0; i--) line_bits.push_back(value[i]);
  endtask

  task automatic put_code(input logic [16:0] entry);
    put_bits(int'(entry[12:0]), int'(entry[16:13]));
  endtask

  task automatic put_run(input logic color, input int pixels);
    int chunk;
    while (pixels >= 64) begin
      chunk = (pixels / 64) * 64;
      if (chunk > 2560) chunk = 2560;
      if (chunk >= 1792) put_code(fgd_pkg::EXT_CODES[(chunk - 1792) / 64]);
      else put_code(color ? fgd_pkg::BLACK_CODES[63 + chunk / 64]
                          : fgd_pkg::WHITE_CODES[63 + chunk / 64]);
      pixels -= chunk;
    end
    put_code(color ? fgd_pkg::BLACK_CODES[pixels] : fgd_pkg::WHITE_CODES[pixels]);
  endtask

  task automatic put_eol();
    put_bits(0, 11 + $urandom_range(0, 3));
    line_bits.push_back(1'b1);
  endtask

  task automatic queue_byte(input logic [7:0] data, input logic eod);
    fgd_pkg::item_t it;
    it.bits = data;
    it.eod  = eod;
    byte_q.push_back(it);
    bytes_queued++;
  endtask

  // Pack whole bytes; with pad set, fill the tail byte with zeros.
  task automatic pack_bytes(input bit pad);
    logic [7:0] data;
    while (line_bits.size() >= 8 || (pad && line_bits.size() > 0)) begin
      for (int k = 0; k < 8; k++) begin
        if (lsb_cfg != 0) data[k] = line_bits.size() ? line_bits.pop_front() : 1'b0;
        else data[7 - k] = line_bits.size() ? line_bits.pop_front() : 1'b0;
      end
      queue_byte(data, 1'b0);
    end
  endtask

  typedef enum int {
    ROW_PLAIN, ROW_FULL, ROW_OVER, ROW_EXT_OVER, ROW_LONG_CODE, ROW_CUT_CODE,
    ROW_WHITE_ZERO, ROW_NOISE
  } row_kind_e;

  task automatic put_row(input row_kind_e kind);
    int   nruns, len;
    logic c;
    case (kind)
      ROW_PLAIN: begin
        nruns = $urandom_range(1, 5);
        c     = 1'b0;
        for (int r = 0; r < nruns; r++) begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 300) : $urandom_range(1, 63);
          put_run(c, len);
          c = ~c;
        end
      end
      ROW_FULL: begin
        put_run(1'b0, 1000);
        put_run(1'b1, 728);
      end
      ROW_OVER: begin
        put_run(1'b0, $urandom_range(1700, 1727));
        put_run(1'b1, $urandom_range(30, 300));
      end
      ROW_EXT_OVER: put_run(1'b0, 1792 + 64 * $urandom_range(0, 12) + $urandom_range(0, 63));
      ROW_LONG_CODE: begin
        // eight zeros, a one, then zeros: no code word, no end of line
        put_run(1'b0, $urandom_range(1, 20));
        put_bits(14'b00000000100000, 14);
      end
      ROW_CUT_CODE: begin
        // a makeup code and half a terminating code, then end of line
        put_run(1'b0, $urandom_range(1, 9));
        put_code(fgd_pkg::BLACK_CODES[64]);
        put_bits(0, 3);
      end
      ROW_WHITE_ZERO: begin
        put_run(1'b0, 0);
        put_run(1'b1, $urandom_range(1, 63));
        put_run(1'b0, $urandom_range(1, 63));
      end
      default: begin
        pack_bytes(1'b1);
        repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    endcase
    put_eol();
    pack_bytes(1'b0);
  endtask

  task automatic random_rows(input int nbytes);
    int first, pick;
    first = bytes_queued;
    while (bytes_queued - first < nbytes) begin
      pick = $urandom_range(0, 11);
      case (pick)
        0: put_row(ROW_NOISE);
        1: put_row(ROW_FULL);
        2: put_row(ROW_OVER);
        3: put_row(ROW_EXT_OVER);
        4: put_row(ROW_LONG_CODE);
        5: put_row(ROW_CUT_CODE);
        6: put_row(ROW_WHITE_ZERO);
        default: put_row(ROW_PLAIN);
      endcase
    end
    pack_bytes(1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer the next byte at the falling edge; hold it until accepted.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    fgd_pkg::item_t it;
    if (rst_ni) begin
      if (!s_axis_tvalid || s_fire) begin
        if (byte_q.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
          it = byte_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= it.bits;
          s_axis_tuser  <= it.eod;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on each accepted byte, check each accepted event.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    fgd_pkg::res_t want;
    s_fire <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) begin
        if (event_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected event: ev %0d start %0d len %0d last %0d", m_axis_tuser,
                     m_axis_tdata[10:0], m_axis_tdata[21:11], m_axis_tlast);
        end else begin
          want = event_q.pop_front();
          if (want.ev !== m_axis_tuser || want.start !== m_axis_tdata[10:0] ||
              want.len !== m_axis_tdata[21:11] || want.last !== m_axis_tlast) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"event mismatch: expected ev %0d start %0d len %0d last %0d,",
                        " got %0d %0d %0d %0d"},
                       want.ev, want.start, want.len, want.last, m_axis_tuser,
                       m_axis_tdata[10:0], m_axis_tdata[21:11], m_axis_tlast);
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("tb_fax_g3_run_length_decoder failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence of phases.
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [1:0] idx, input int value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= 3'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      fgd_pkg::CFG_LSB_FIRST: lsb_cfg = value & 1;
      fgd_pkg::CFG_SYNC_EOLS: begin
        if (dec_mode == fgd_pkg::MODE_SYNC) sync_cnt = value;
      end
      default: page_cfg = value;
    endcase
  endtask

  // Hold until every byte is in and every event is out, then let the
  // bit engine finish any byte that produces no event.
  task automatic drain();
    do @(negedge clk_i);
    while (byte_q.size() > 0 || s_axis_tvalid || event_q.size() > 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = fgd_pkg::CFG_LSB_FIRST;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    s_fire        = 1'b0;
    gap_pct       = 0;
    stall_pct     = 0;
    hold_reqs     = 0;
    hold_seen     = 0;
    hold_left     = 0;
    mismatches    = 0;
    idle_cycles   = 0;
    bytes_queued  = 0;
    lsb_cfg       = 0;
    page_cfg      = 3;
    dec_mode      = fgd_pkg::MODE_SYNC;
    sync_cnt      = 1;
    zero_cnt      = 0;
    empty_cnt     = 0;
    restart_row();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: sync over noise and four ends of line, then each row shape.
    write_reg(fgd_pkg::CFG_SYNC_EOLS, 4);
    write_reg(fgd_pkg::CFG_PAGE_EOLS, 6);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'h00, 1'b0);
    repeat (4) put_eol();
    put_row(ROW_PLAIN);
    put_row(ROW_WHITE_ZERO);
    put_row(ROW_FULL);
    put_row(ROW_OVER);
    put_row(ROW_EXT_OVER);
    put_row(ROW_LONG_CODE);
    put_row(ROW_CUT_CODE);
    repeat (5) put_eol();   // five empty rows, one short of the page end
    put_row(ROW_PLAIN);
    pack_bytes(1'b1);
    drain();

    // Random rows under each traffic profile.
    write_reg(fgd_pkg::CFG_LSB_FIRST, 1);
    write_reg(fgd_pkg::CFG_SYNC_EOLS, 1);
    gap_pct = 83;
    random_rows(10);
    drain();

    write_reg(fgd_pkg::CFG_LSB_FIRST, 0);
    gap_pct   = 0;
    stall_pct = 83;
    random_rows(10);
    drain();

    write_reg(fgd_pkg::CFG_LSB_FIRST, 1);
    gap_pct   = 16;
    stall_pct = 16;
    random_rows(10);
    drain();

    // Long receiver hold-off while the sender keeps offering bytes.
    gap_pct   = 0;
    stall_pct = 0;
    hold_reqs++;
    random_rows(10);
    drain();

    // End of data in the middle of a row, then input the page end ignores.
    write_reg(fgd_pkg::CFG_PAGE_EOLS, 1);
    write_reg(fgd_pkg::CFG_LSB_FIRST, 0);
    put_run(1'b0, $urandom_range(1, 63));
    pack_bytes(1'b1);
    queue_byte(8'($urandom_range(0, 255)), 1'b1);
    queue_byte(8'($urandom_range(0, 255)), 1'b0);
    queue_byte(8'($urandom_range(0, 255)), 1'b1);
    drain();

    if (mismatches == 0 && event_q.size() == 0) begin
      $display("tb_fax_g3_run_length_decoder passed");
    end else begin
      $display("tb_fax_g3_run_length_decoder failed");
    end
    $finish;
  end

endmodule
